>>> rtl/awo_pkg.sv
`default_nettype none

package awo_pkg;

    // Field and datapath widths
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int KIND_W    = 2;
    localparam int FREQ_W    = 31;
    localparam int GAIN_W    = 16;
    localparam int COUNT_W   = 7;
    localparam int TIME_W    = 32;
    localparam int SAMPLE_W  = 16;
    localparam int FRAC_W    = 40;
    localparam int ENTRY_W   = 15;
    localparam int WGT_W     = 25;
    localparam int ACC_W     = 48;
    localparam int Y_W       = 34;
    localparam int PROD_W    = 60;

    // Rounding shifts
    localparam int unsigned ACC_SHIFT = 15;
    localparam int unsigned Q24_SHIFT = 24;

    // Register reset values
    localparam logic [FREQ_W-1:0]  FREQ_RESET  = FREQ_W'(28835840);
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(32768);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);

    // Arithmetic constants
    localparam int unsigned      ONE_Q24     = 32'd16777216;
    localparam int unsigned      SAW_NORM    = 32'd9078601;
    localparam int unsigned      TRI_NORM    = 32'd13599099;
    localparam longint unsigned  HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned  ONE_Q30     = 64'd1073741824;

    typedef enum logic [KIND_W-1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_SAW      = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } wave_kind_t;

    typedef enum logic [1:0] {
        REG_WAVE_KIND      = 2'd0,
        REG_FREQUENCY_HZ   = 2'd1,
        REG_AMPLITUDE_GAIN = 2'd2,
        REG_HARMONIC_COUNT = 2'd3
    } reg_index_t;

    typedef struct packed {
        wave_kind_t         wave_kind;
        logic [FREQ_W-1:0]  frequency_hz;
        logic [GAIN_W-1:0]  amplitude_gain;
        logic [COUNT_W-1:0] harmonic_count;
    } cfg_t;

    // Divide by 2^sh and round half away from zero
    function automatic logic signed [PROD_W-1:0] rnd_shift(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              sh
    );
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] half;
        logic [PROD_W-1:0] r;
        mag  = v[PROD_W-1] ? $unsigned(-v) : $unsigned(v);
        half = PROD_W'(1) << (sh - 1);
        r    = (mag + half) >> sh;
        return v[PROD_W-1] ? -$signed(r) : $signed(r);
    endfunction

endpackage

`default_nettype wire

>>> rtl/awo_sine_rom.sv
`default_nettype none

module awo_sine_rom #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH + 1)
) (
    input  logic                        aclk,
    input  logic [AW-1:0]               addr,
    output logic [awo_pkg::ENTRY_W-1:0] rd_data
);

    typedef logic [awo_pkg::ENTRY_W-1:0] rom_t [DEPTH + 1];

    // Quarter-wave sine, Q15, from a Q30 Taylor series up to x^13
    function automatic rom_t build_rom();
        rom_t              tbl;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   outv;
        longint signed     sum;
        for (int k = 0; k <= DEPTH; k++) begin
            x    = (64'(k) * awo_pkg::HALF_PI_Q30) / DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int i = 1; i <= 6; i++) begin
                term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
                if ((i % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > longint'(awo_pkg::ONE_Q30)) begin
                sum = longint'(awo_pkg::ONE_Q30);
            end
            outv = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (outv > 64'd32767) begin
                outv = 64'd32767;
            end
            tbl[k] = awo_pkg::ENTRY_W'(outv);
        end
        return tbl;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [awo_pkg::ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        rd_data_reg <= ROM[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/awo_sine_unit.sv
`default_nettype none

module awo_sine_unit #(
    parameter int DEPTH = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    input  logic [awo_pkg::FRAC_W-1:0]          in_phase,
    output logic                                out_valid,
    output logic signed [awo_pkg::SAMPLE_W-1:0] out_sine
);

    localparam int IDX_W = $clog2(4 * DEPTH);
    localparam int SCL_W = $clog2(4 * DEPTH + 1);
    localparam int AW    = $clog2(DEPTH + 1);
    localparam int MUL_W = awo_pkg::FRAC_W + SCL_W;

    localparam logic [SCL_W-1:0] SCALE = SCL_W'(4 * DEPTH);
    localparam logic [IDX_W-1:0] Q1    = IDX_W'(DEPTH);
    localparam logic [IDX_W-1:0] Q2    = IDX_W'(2 * DEPTH);
    localparam logic [IDX_W-1:0] Q3    = IDX_W'(3 * DEPTH);

    logic [MUL_W-1:0]   scaled;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   k_lin;
    logic [IDX_W-1:0]   k_fold;
    logic [1:0]         quad;
    logic [AW-1:0]      addr_reg;
    logic               neg_reg;
    logic               neg2_reg;
    logic [awo_pkg::ENTRY_W-1:0] rom_data;
    logic signed [awo_pkg::SAMPLE_W-1:0] sine_next;
    logic signed [awo_pkg::SAMPLE_W-1:0] sine_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic               v4_reg;

    // Table index: floor(phase * 4 * DEPTH / 2^40)
    assign scaled = MUL_W'(in_phase) * MUL_W'(SCALE);

    // Fold the index into the first quadrant
    always_comb begin
        if (idx_reg < Q1) begin
            quad  = 2'd0;
            k_lin = idx_reg;
        end else if (idx_reg < Q2) begin
            quad  = 2'd1;
            k_lin = idx_reg - Q1;
        end else if (idx_reg < Q3) begin
            quad  = 2'd2;
            k_lin = idx_reg - Q2;
        end else begin
            quad  = 2'd3;
            k_lin = idx_reg - Q3;
        end
        k_fold = quad[0] ? (Q1 - k_lin) : k_lin;
    end

    awo_sine_rom #(
        .DEPTH (DEPTH)
    ) u_rom (
        .aclk    (aclk),
        .addr    (addr_reg),
        .rd_data (rom_data)
    );

    assign sine_next = neg2_reg ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
        idx_reg  <= scaled[awo_pkg::FRAC_W +: IDX_W];
        addr_reg <= AW'(k_fold);
        neg_reg  <= quad[1];
        neg2_reg <= neg_reg;
        sine_reg <= sine_next;
    end

    assign out_valid = v4_reg;
    assign out_sine  = sine_reg;

endmodule

`default_nettype wire

>>> rtl/awo_regs.sv
`default_nettype none

module awo_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [awo_pkg::ADDR_W-1:0]  paddr,
    input  logic [awo_pkg::DATA_W-1:0]  pwdata,
    output logic [awo_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output awo_pkg::cfg_t               cfg
);

    logic                           wr_en;
    awo_pkg::reg_index_t            reg_sel;
    awo_pkg::wave_kind_t            wave_kind_reg;
    logic [awo_pkg::FREQ_W-1:0]     frequency_hz_reg;
    logic [awo_pkg::GAIN_W-1:0]     amplitude_gain_reg;
    logic [awo_pkg::COUNT_W-1:0]    harmonic_count_reg;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = awo_pkg::reg_index_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_kind_reg      <= awo_pkg::WAVE_SINE;
            frequency_hz_reg   <= awo_pkg::FREQ_RESET;
            amplitude_gain_reg <= awo_pkg::GAIN_RESET;
            harmonic_count_reg <= awo_pkg::COUNT_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                awo_pkg::REG_WAVE_KIND: begin
                    wave_kind_reg <= awo_pkg::wave_kind_t'(pwdata[awo_pkg::KIND_W-1:0]);
                end
                awo_pkg::REG_FREQUENCY_HZ: begin
                    frequency_hz_reg <= pwdata[awo_pkg::FREQ_W-1:0];
                end
                awo_pkg::REG_AMPLITUDE_GAIN: begin
                    amplitude_gain_reg <= pwdata[awo_pkg::GAIN_W-1:0];
                end
                awo_pkg::REG_HARMONIC_COUNT: begin
                    harmonic_count_reg <= pwdata[awo_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            awo_pkg::REG_WAVE_KIND:      prdata = awo_pkg::DATA_W'(wave_kind_reg);
            awo_pkg::REG_FREQUENCY_HZ:   prdata = awo_pkg::DATA_W'(frequency_hz_reg);
            awo_pkg::REG_AMPLITUDE_GAIN: prdata = awo_pkg::DATA_W'(amplitude_gain_reg);
            awo_pkg::REG_HARMONIC_COUNT: prdata = awo_pkg::DATA_W'(harmonic_count_reg);
            default:                     prdata = '0;
        endcase
    end

    assign cfg.wave_kind      = wave_kind_reg;
    assign cfg.frequency_hz   = frequency_hz_reg;
    assign cfg.amplitude_gain = amplitude_gain_reg;
    assign cfg.harmonic_count = harmonic_count_reg;

endmodule

`default_nettype wire

>>> rtl/awo_core.sv
`default_nettype none

module awo_core #(
    parameter int MAX_PARTIALS     = 64,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  awo_pkg::cfg_t                       cfg,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [awo_pkg::TIME_W-1:0]          s_time_seconds,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [awo_pkg::SAMPLE_W-1:0] m_sample_value,
    output logic                                m_clipped
);

    localparam int CW     = $clog2(MAX_PARTIALS + 1);
    localparam int IW     = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
    localparam int CMP_W  = (CW > awo_pkg::COUNT_W) ? CW : awo_pkg::COUNT_W;
    localparam int FP_W   = awo_pkg::FREQ_W + awo_pkg::TIME_W;
    localparam int FRAC_W = awo_pkg::FRAC_W;
    localparam int PROD_W = awo_pkg::PROD_W;
    localparam int ACC_W  = awo_pkg::ACC_W;
    localparam int Y_W    = awo_pkg::Y_W;
    localparam int WGT_W  = awo_pkg::WGT_W;

    localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(32767);
    localparam logic signed [PROD_W-1:0] SAT_MIN = PROD_W'(-32768);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRAC,
        ST_ISSUE,
        ST_DRAIN,
        ST_ROUND1,
        ST_NORM,
        ST_ROUND2,
        ST_GAIN,
        ST_OUT
    } state_t;

    // Q24 reciprocal tables, one entry per partial slot
    logic [WGT_W-1:0] rcp_odd [MAX_PARTIALS];
    logic [WGT_W-1:0] rcp_int [MAX_PARTIALS];
    logic [WGT_W-1:0] rcp_sq  [MAX_PARTIALS];

    for (genvar g = 0; g < MAX_PARTIALS; g++) begin : g_rcp
        localparam int unsigned NODD  = 2 * g + 1;
        localparam int unsigned NINT  = g + 1;
        localparam int unsigned NSQ   = NODD * NODD;
        localparam int unsigned R_ODD = (awo_pkg::ONE_Q24 + NODD / 2) / NODD;
        localparam int unsigned R_INT = (awo_pkg::ONE_Q24 + NINT / 2) / NINT;
        localparam int unsigned R_SQ  = (awo_pkg::ONE_Q24 + NSQ / 2) / NSQ;
        assign rcp_odd[g] = WGT_W'(R_ODD);
        assign rcp_int[g] = WGT_W'(R_INT);
        assign rcp_sq[g]  = WGT_W'(R_SQ);
    end

    state_t                      state_reg,  state_next;
    logic [awo_pkg::TIME_W-1:0]  t_reg,      t_next;
    logic [FRAC_W-1:0]           phase_reg,  phase_next;
    logic [FRAC_W-1:0]           step_reg,   step_next;
    logic [CW-1:0]               nterms_reg, nterms_next;
    logic [CW-1:0]               issue_reg,  issue_next;
    logic [CW-1:0]               j_reg,      j_next;
    logic [CW-1:0]               done_reg,   done_next;
    logic signed [PROD_W-1:0]    prod_reg,   prod_next;
    logic                        prod_v_reg, prod_v_next;
    logic                        prod_neg_reg, prod_neg_next;
    logic signed [ACC_W-1:0]     acc_reg,    acc_next;
    logic signed [Y_W-1:0]       y_reg,      y_next;
    logic                        m_valid_reg, m_valid_next;
    logic signed [awo_pkg::SAMPLE_W-1:0] m_sample_reg, m_sample_next;
    logic                        m_clipped_reg, m_clipped_next;

    logic [FP_W-1:0]             frac_prod;
    logic [FRAC_W-1:0]           frac;
    logic [CMP_W-1:0]            cnt_ext;
    logic [CMP_W-1:0]            cnt_sat;
    logic [CW-1:0]               p_eff;
    logic [CW-1:0]               nterms_c;
    logic                        odd_only;
    logic                        sin_in_v;
    logic                        sine_v;
    logic signed [awo_pkg::SAMPLE_W-1:0] sine_val;
    logic [WGT_W-1:0]            weight;
    logic [WGT_W-1:0]            norm;
    logic signed [Y_W-1:0]       mul_a;
    logic [WGT_W-1:0]            mul_b;
    logic signed [PROD_W-1:0]    mul_p;
    logic signed [PROD_W-1:0]    r_out;

    // Fundamental phase: low 40 bits of Q15.16 * Q8.24
    assign frac_prod = FP_W'(cfg.frequency_hz) * FP_W'(t_reg);
    assign frac      = frac_prod[FRAC_W-1:0];

    assign cnt_ext  = CMP_W'(cfg.harmonic_count);
    assign cnt_sat  = (cnt_ext > CMP_W'(MAX_PARTIALS)) ? CMP_W'(MAX_PARTIALS) : cnt_ext;
    assign p_eff    = CW'(cnt_sat);
    assign odd_only = (cfg.wave_kind == awo_pkg::WAVE_SQUARE)
                   || (cfg.wave_kind == awo_pkg::WAVE_TRIANGLE);

    always_comb begin
        case (cfg.wave_kind)
            awo_pkg::WAVE_SINE:     nterms_c = CW'(1);
            awo_pkg::WAVE_SQUARE:   nterms_c = p_eff;
            awo_pkg::WAVE_SAW:      nterms_c = (p_eff > CW'(1)) ? (p_eff - CW'(1)) : '0;
            awo_pkg::WAVE_TRIANGLE: nterms_c = p_eff;
            default:                nterms_c = '0;
        endcase
    end

    always_comb begin
        case (cfg.wave_kind)
            awo_pkg::WAVE_SAW: begin
                weight = rcp_int[j_reg[IW-1:0]];
                norm   = WGT_W'(awo_pkg::SAW_NORM);
            end
            awo_pkg::WAVE_TRIANGLE: begin
                weight = rcp_sq[j_reg[IW-1:0]];
                norm   = WGT_W'(awo_pkg::TRI_NORM);
            end
            default: begin
                weight = rcp_odd[j_reg[IW-1:0]];
                norm   = WGT_W'(awo_pkg::ONE_Q24);
            end
        endcase
    end

    assign sin_in_v = (state_reg == ST_ISSUE);

    awo_sine_unit #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sin_in_v),
        .in_phase  (phase_reg),
        .out_valid (sine_v),
        .out_sine  (sine_val)
    );

    // Shared multiplier: partial weights, then normalization, then gain
    always_comb begin
        case (state_reg)
            ST_NORM: begin
                mul_a = y_reg;
                mul_b = norm;
            end
            ST_GAIN: begin
                mul_a = y_reg;
                mul_b = WGT_W'(cfg.amplitude_gain);
            end
            default: begin
                mul_a = Y_W'(sine_val);
                mul_b = weight;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));
    assign r_out = awo_pkg::rnd_shift(prod_reg, awo_pkg::Q24_SHIFT);

    always_comb begin
        state_next     = state_reg;
        t_next         = t_reg;
        phase_next     = phase_reg;
        step_next      = step_reg;
        nterms_next    = nterms_reg;
        issue_next     = issue_reg;
        j_next         = j_reg;
        done_next      = done_reg;
        prod_next      = prod_reg;
        prod_v_next    = sine_v;
        prod_neg_next  = (cfg.wave_kind == awo_pkg::WAVE_TRIANGLE) && j_reg[0];
        acc_next       = acc_reg;
        y_next         = y_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_sample_next  = m_sample_reg;
        m_clipped_next = m_clipped_reg;

        if (sine_v || (state_reg == ST_NORM) || (state_reg == ST_GAIN)) begin
            prod_next = mul_p;
        end
        if (sine_v) begin
            j_next = j_reg + CW'(1);
        end
        if (prod_v_reg) begin
            acc_next  = prod_neg_reg ? (acc_reg - ACC_W'(prod_reg))
                                     : (acc_reg + ACC_W'(prod_reg));
            done_next = done_reg + CW'(1);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    t_next     = s_time_seconds;
                    acc_next   = '0;
                    issue_next = '0;
                    j_next     = '0;
                    done_next  = '0;
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC: begin
                phase_next  = frac;
                step_next   = odd_only ? {frac[FRAC_W-2:0], 1'b0} : frac;
                nterms_next = nterms_c;
                state_next  = (nterms_c == '0) ? ST_DRAIN : ST_ISSUE;
            end
            ST_ISSUE: begin
                phase_next = phase_reg + step_reg;
                issue_next = issue_reg + CW'(1);
                if (issue_next == nterms_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (done_reg == nterms_reg) begin
                    state_next = ST_ROUND1;
                end
            end
            ST_ROUND1: begin
                y_next = Y_W'(awo_pkg::rnd_shift(PROD_W'(acc_reg), awo_pkg::ACC_SHIFT));
                state_next = ST_NORM;
            end
            ST_NORM: begin
                state_next = ST_ROUND2;
            end
            ST_ROUND2: begin
                y_next = Y_W'(awo_pkg::rnd_shift(prod_reg, awo_pkg::Q24_SHIFT));
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (r_out > SAT_MAX) begin
                        m_sample_next  = awo_pkg::SAMPLE_W'(SAT_MAX);
                        m_clipped_next = 1'b1;
                    end else if (r_out < SAT_MIN) begin
                        m_sample_next  = awo_pkg::SAMPLE_W'(SAT_MIN);
                        m_clipped_next = 1'b1;
                    end else begin
                        m_sample_next  = awo_pkg::SAMPLE_W'(r_out);
                        m_clipped_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            issue_reg   <= '0;
            j_reg       <= '0;
            done_reg    <= '0;
            nterms_reg  <= '0;
            prod_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            issue_reg   <= issue_next;
            j_reg       <= j_next;
            done_reg    <= done_next;
            nterms_reg  <= nterms_next;
            prod_v_reg  <= prod_v_next;
            m_valid_reg <= m_valid_next;
        end
        t_reg         <= t_next;
        phase_reg     <= phase_next;
        step_reg      <= step_next;
        prod_reg      <= prod_next;
        prod_neg_reg  <= prod_neg_next;
        acc_reg       <= acc_next;
        y_reg         <= y_next;
        m_sample_reg  <= m_sample_next;
        m_clipped_reg <= m_clipped_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_sample_value = m_sample_reg;
    assign m_clipped      = m_clipped_reg;

endmodule

`default_nettype wire

>>> rtl/additive_waveform_oscillator.sv
// Additive oscillator: one Q1.15 sample per Q8.24 time stamp, summed from sine partials.
// Partials summed: 1 for sine, the harmonic count (capped at MAX_PARTIALS) for
// square/triangle, one less for sawtooth. A new time stamp is taken only once the
// previous sample sits in the output register; the shared multiply-accumulate takes
// one partial per cycle.
// Reset (aresetn low, synchronous): idle, sine, 440 Hz, unity gain, 8 partials.
`default_nettype none

module additive_waveform_oscillator #(
    parameter int MAX_PARTIALS     = 64,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Input channel: one time stamp per transaction
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [awo_pkg::TIME_W-1:0]          s_time_seconds,

    // Result channel: one sample per transaction
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [awo_pkg::SAMPLE_W-1:0] m_sample_value,
    output logic                                m_clipped,

    // Register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [awo_pkg::ADDR_W-1:0]          paddr,
    input  logic [awo_pkg::DATA_W-1:0]          pwdata,
    output logic [awo_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    // Live configuration, to be changed only while the core is idle; the block does not enforce it
    awo_pkg::cfg_t cfg;

    // Register file: wave_kind at 0x0, frequency_hz at 0x4,
    // amplitude_gain at 0x8, harmonic count at 0xC. Writes land on the
    // access cycle; pready stays high.
    awo_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Core sequence per transaction:
    //   - form the 40-bit fundamental phase fraction from frequency * time
    //   - issue one partial phase per cycle into the sine pipeline
    //     (index scale, quadrant fold, quarter-wave ROM, sign)
    //   - weight each sine by its Q24 reciprocal on the shared multiplier
    //     and accumulate, subtracting every other triangle term
    //   - reuse the same multiplier for the mode normalization and the gain,
    //     rounding half away from zero between steps
    //   - saturate to 16 bits and park the sample in the output register,
    //     which frees the core to take the next time stamp
    awo_core #(
        .MAX_PARTIALS     (MAX_PARTIALS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_time_seconds (s_time_seconds),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_value (m_sample_value),
        .m_clipped      (m_clipped)
    );

endmodule

`default_nettype wire

>>> dv/awo_sample_checker.sv
module awo_sample_checker
    import awo_pkg::*;
#(
    parameter int MAX_PARTIALS     = 64,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [TIME_W-1:0]          s_time_seconds,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [SAMPLE_W-1:0] m_sample_value,
    input  logic                       m_clipped,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    input  logic [DATA_W-1:0]          prdata,
    input  logic                       pready,
    output int                         pending_samples,
    output int                         mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned PHASE_MASK = (64'd1 << FRAC_W) - 64'd1;

    typedef struct packed {
        logic [TIME_W-1:0]          stamp;
        logic signed [SAMPLE_W-1:0] value;
        logic                       clipped;
    } sample_t;

    // Register shadow, tracked from the APB writes
    wave_kind_t         kind_q;
    logic [FREQ_W-1:0]  freq_q;
    logic [GAIN_W-1:0]  gain_q;
    logic [COUNT_W-1:0] partials_q;

    int unsigned quarter_rom [0:SINE_TABLE_DEPTH];
    sample_t     expected_samples [$];
    int          outstanding = 0;
    int          mismatches  = 0;

    assign pending_samples = outstanding;
    assign mismatch_count  = mismatches;

    task automatic report_mismatch(input string detail);
        mismatches++;
        $display("%0t ns  mismatch: %s", $time, detail);
    endtask

    // sin(pi/2 * k / depth) in Q15 from a Q30 Taylor series
    function automatic int unsigned quarter_entry_q15(input int unsigned k);
        longint unsigned k64;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned rounded;
        longint          total;
        k64   = k;
        x     = (k64 * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
        x2    = (x * x) >> 30;
        term  = x;
        total = longint'(x);
        for (int i = 1; i <= 6; i++) begin
            term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
            if (i % 2 == 1) begin
                total -= longint'(term);
            end else begin
                total += longint'(term);
            end
        end
        if (total < 0) begin
            total = 0;
        end
        if (total > longint'(ONE_Q30)) begin
            total = longint'(ONE_Q30);
        end
        rounded = (64'(total) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (rounded > 64'd32767) begin
            rounded = 64'd32767;
        end
        return 32'(rounded);
    endfunction

    function automatic int sine_at_phase(input longint unsigned phase);
        longint unsigned idx;
        int unsigned     quad;
        int unsigned     k;
        int              v;
        idx  = ((phase & PHASE_MASK) * 64'(4 * SINE_TABLE_DEPTH)) >> FRAC_W;
        quad = 32'(idx / 64'(SINE_TABLE_DEPTH)) & 32'd3;
        k    = 32'(idx % 64'(SINE_TABLE_DEPTH));
        if (quad & 32'd1) begin
            k = SINE_TABLE_DEPTH - k;
        end
        v = int'(quarter_rom[k]);
        return (quad & 32'd2) ? -v : v;
    endfunction

    // Divide by 2^sh, ties away from zero
    function automatic longint round_away(input longint v, input int unsigned sh);
        longint unsigned mag;
        longint unsigned r;
        if (v < 0) begin
            mag = -v;
        end else begin
            mag = v;
        end
        r = (mag + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint partial_weight(input longint unsigned d);
        return longint'((64'(ONE_Q24) + d / 2) / d);
    endfunction

    function automatic sample_t predict_sample(input logic [TIME_W-1:0] stamp);
        longint unsigned freq64;
        longint unsigned stamp64;
        longint unsigned frac;
        longint unsigned n;
        longint          acc;
        longint          y;
        longint          r;
        longint          gain64;
        int unsigned     count;
        sample_t         res;
        freq64  = freq_q;
        stamp64 = stamp;
        gain64  = gain_q;
        frac    = (freq64 * stamp64) & PHASE_MASK;
        count   = (partials_q > MAX_PARTIALS) ? MAX_PARTIALS : partials_q;
        acc     = 0;
        case (kind_q)
            WAVE_SINE: begin
                acc = longint'(sine_at_phase(frac)) * longint'(ONE_Q24);
            end
            WAVE_SQUARE: begin
                for (int unsigned i = 0; i < count; i++) begin
                    n = 2 * i + 1;
                    acc += longint'(sine_at_phase(frac * n)) * partial_weight(n);
                end
            end
            WAVE_SAW: begin
                for (int unsigned h = 1; h < count; h++) begin
                    n = h;
                    acc += longint'(sine_at_phase(frac * n)) * partial_weight(n);
                end
            end
            default: begin
                for (int unsigned i = 0; i < count; i++) begin
                    n = 2 * i + 1;
                    if (i % 2 == 1) begin
                        acc -= longint'(sine_at_phase(frac * n)) * partial_weight(n * n);
                    end else begin
                        acc += longint'(sine_at_phase(frac * n)) * partial_weight(n * n);
                    end
                end
            end
        endcase
        y = round_away(acc, ACC_SHIFT);
        if (kind_q == WAVE_SAW) begin
            y = round_away(y * longint'(SAW_NORM), Q24_SHIFT);
        end else if (kind_q == WAVE_TRIANGLE) begin
            y = round_away(y * longint'(TRI_NORM), Q24_SHIFT);
        end
        r = round_away(y * gain64, Q24_SHIFT);
        res.stamp   = stamp;
        res.clipped = 1'b0;
        if (r > 32767) begin
            r           = 32767;
            res.clipped = 1'b1;
        end else if (r < -32768) begin
            r           = -32768;
            res.clipped = 1'b1;
        end
        res.value = SAMPLE_W'(r);
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] shadow_value(input reg_index_t idx);
        case (idx)
            REG_WAVE_KIND:      return DATA_W'(kind_q);
            REG_FREQUENCY_HZ:   return DATA_W'(freq_q);
            REG_AMPLITUDE_GAIN: return DATA_W'(gain_q);
            default:            return DATA_W'(partials_q);
        endcase
    endfunction

    initial begin
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            quarter_rom[k] = quarter_entry_q15(k);
        end
    end

    always @(posedge aclk) begin
        sample_t    want;
        reg_index_t idx;
        if (!aresetn) begin
            kind_q      = WAVE_SINE;
            freq_q      = FREQ_RESET;
            gain_q      = GAIN_RESET;
            partials_q  = COUNT_RESET;
            expected_samples.delete();
            outstanding = 0;
        end else begin
            idx = reg_index_t'(paddr[ADDR_W-1:2]);
            if (psel && penable && pready && pwrite) begin
                case (idx)
                    REG_WAVE_KIND:      kind_q     = wave_kind_t'(pwdata[KIND_W-1:0]);
                    REG_FREQUENCY_HZ:   freq_q     = pwdata[FREQ_W-1:0];
                    REG_AMPLITUDE_GAIN: gain_q     = pwdata[GAIN_W-1:0];
                    default:            partials_q = pwdata[COUNT_W-1:0];
                endcase
            end else if (psel && penable && pready) begin
                if (prdata !== shadow_value(idx)) begin
                    report_mismatch($sformatf("register %s read 0x%08h, expected 0x%08h",
                                              idx.name(), prdata, shadow_value(idx)));
                end
            end

            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("sample %0d clipped %0b with nothing pending",
                                              m_sample_value, m_clipped));
                end else begin
                    want = expected_samples.pop_front();
                    if (m_sample_value !== want.value) begin
                        report_mismatch($sformatf("t=0x%08h sample_value %0d, expected %0d",
                                                  want.stamp, m_sample_value, want.value));
                    end
                    if (m_clipped !== want.clipped) begin
                        report_mismatch($sformatf("t=0x%08h clipped %0b, expected %0b",
                                                  want.stamp, m_clipped, want.clipped));
                    end
                end
            end

            if (s_valid && s_ready) begin
                expected_samples.push_back(predict_sample(s_time_seconds));
            end
            outstanding = expected_samples.size();
        end
    end

endmodule

>>> dv/tb_additive_waveform_oscillator.sv
module tb_additive_waveform_oscillator;
    timeunit 1ns;
    timeprecision 1ps;

    import awo_pkg::*;

    localparam int MAX_PARTIALS     = 64;
    localparam int TABLE_DEPTH      = 1024;
    localparam int RANDOM_ITEMS     = 1400;
    // Leave wide margin over the slowest legal run
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int LONG_HOLD_CYCLES = 400;
    // Latency is longest at 64 partials
    localparam int SETTLE_CYCLES    = 100;

    localparam logic [FREQ_W-1:0] FREQ_TOP  = FREQ_W'(1310720000);
    localparam logic [FREQ_W-1:0] FREQ_1HZ  = FREQ_W'(65536);
    localparam logic [FREQ_W-1:0] FREQ_1KHZ = FREQ_W'(65536000);

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [TIME_W-1:0]          s_time_seconds;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W-1:0] m_sample_value;
    logic                       m_clipped;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    int                         pending_samples;
    int                         mismatch_count;

    // Flow control knobs shared between the stimulus and the result sink
    bit steady_flow  = 1'b0;
    bit hold_results = 1'b0;

    additive_waveform_oscillator #(
        .MAX_PARTIALS     (MAX_PARTIALS),
        .SINE_TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_time_seconds (s_time_seconds),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_value (m_sample_value),
        .m_clipped      (m_clipped),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Predict every accepted time stamp and score every returned sample
    awo_sample_checker #(
        .MAX_PARTIALS     (MAX_PARTIALS),
        .SINE_TABLE_DEPTH (TABLE_DEPTH)
    ) scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_time_seconds  (s_time_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample_value  (m_sample_value),
        .m_clipped       (m_clipped),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .pending_samples (pending_samples),
        .mismatch_count  (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: stop a hung run
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(12, 40);
    endfunction

    // Result sink: random ready pattern, with one long hold-off on request
    initial begin
        int run;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_results) begin
                // Hold ready low so the block fills and backs up its input
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                hold_results = 1'b0;
            end else if (steady_flow || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                run = steady_flow ? 1 : $urandom_range(1, 12);
                repeat (run - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b0;
                run = 1 + pick_gap();
                repeat (run - 1) @(negedge aclk);
            end
        end
    end

    // Offer one time stamp, after an optional gap, and hold it until the transaction
    task automatic offer_time(input logic [TIME_W-1:0] stamp);
        int gap;
        gap = steady_flow ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            // Drop valid and scramble the idle payload
            s_valid        <= 1'b0;
            s_time_seconds <= $urandom;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_time_seconds <= stamp;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic stop_offering();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Pause the sender until every outstanding sample has come back
    task automatic wait_drained();
        while (pending_samples != 0) @(negedge aclk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready
    task automatic apb_access(input logic write, input reg_index_t idx,
                              input logic [DATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Half the writes carry junk above the field, which the block must drop
    function automatic logic [DATA_W-1:0] with_junk(input logic [DATA_W-1:0] field,
                                                    input int width);
        if ($urandom_range(0, 1) == 0) begin
            return field;
        end
        return (DATA_W'($urandom) << width) | field;
    endfunction

    // Drain, write all four registers, then read them back for the checker
    task automatic program_settings(input wave_kind_t kind, input logic [FREQ_W-1:0] freq,
                                    input logic [GAIN_W-1:0] gain,
                                    input logic [COUNT_W-1:0] parts);
        stop_offering();
        wait_drained();
        apb_access(1'b1, REG_WAVE_KIND,      with_junk(DATA_W'(kind), KIND_W));
        apb_access(1'b1, REG_FREQUENCY_HZ,   with_junk(DATA_W'(freq), FREQ_W));
        apb_access(1'b1, REG_AMPLITUDE_GAIN, with_junk(DATA_W'(gain), GAIN_W));
        apb_access(1'b1, REG_HARMONIC_COUNT, with_junk(DATA_W'(parts), COUNT_W));
        for (int i = 0; i < 4; i++) begin
            apb_access(1'b0, reg_index_t'(i), '0);
        end
    endtask

    initial begin
        int                 sent;
        int                 phase_idx;
        int                 phase_len;
        bit                 ramp;
        logic [TIME_W-1:0]  stamp;
        logic [TIME_W-1:0]  step;
        wave_kind_t         kind;
        logic [FREQ_W-1:0]  freq;
        logic [GAIN_W-1:0]  gain;
        logic [COUNT_W-1:0] parts;

        s_valid        = 1'b0;
        s_time_seconds = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        aresetn        = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Read back reset values, then run a few samples on them
        for (int i = 0; i < 4; i++) begin
            apb_access(1'b0, reg_index_t'(i), '0);
        end
        offer_time('0);
        offer_time('1);
        offer_time($urandom);

        // Square, top frequency, max gain, partial count above the limit: clamps
        program_settings(WAVE_SQUARE, FREQ_TOP, '1, 7'd127);
        offer_time(32'h0000_1000);
        offer_time($urandom);
        offer_time('1);

        // Sawtooth with one partial sums nothing
        program_settings(WAVE_SAW, FREQ_RESET, GAIN_RESET, 7'd1);
        offer_time(32'h0000_8000);
        offer_time($urandom);

        // No partials at all for sawtooth, triangle and square
        program_settings(WAVE_SAW, FREQ_RESET, GAIN_RESET, 7'd0);
        offer_time($urandom);
        program_settings(WAVE_TRIANGLE, FREQ_RESET, GAIN_RESET, 7'd0);
        offer_time($urandom);
        offer_time('1);
        program_settings(WAVE_SQUARE, FREQ_RESET, GAIN_RESET, 7'd0);
        offer_time($urandom);

        // Zero frequency pins the phase at zero
        program_settings(WAVE_TRIANGLE, '0, '1, 7'd64);
        offer_time('1);
        offer_time($urandom);

        // Widest frequency field, zero gain
        program_settings(WAVE_SINE, '1, '0, COUNT_RESET);
        offer_time('1);
        offer_time($urandom);

        // Full sawtooth at max gain
        program_settings(WAVE_SAW, FREQ_1KHZ, '1, 7'd64);
        offer_time(32'h0000_0400);
        offer_time($urandom);
        offer_time($urandom);

        // Pure sine at 1 Hz, peak and trough at max gain: saturate both ways
        program_settings(WAVE_SINE, FREQ_1HZ, '1, COUNT_RESET);
        offer_time(32'h0040_0000);
        offer_time(32'h00C0_0000);

        // Random phases: new settings each time, mostly sampled-time ramps
        sent      = 0;
        phase_idx = 0;
        while (sent < RANDOM_ITEMS) begin
            kind = wave_kind_t'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       freq = '0;
                1:       freq = '1;
                2:       freq = FREQ_TOP;
                3, 4:    freq = FREQ_W'($urandom_range(20, 20000)) << 16;
                5, 6:    freq = FREQ_W'($urandom_range(0, 1310720000));
                default: freq = FREQ_W'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0:       gain = '0;
                1:       gain = '1;
                2:       gain = GAIN_RESET;
                default: gain = GAIN_W'($urandom);
            endcase
            case ($urandom_range(0, 7))
                0:       parts = 7'd0;
                1:       parts = 7'd1;
                2:       parts = 7'd64;
                3:       parts = COUNT_W'($urandom_range(65, 127));
                default: parts = COUNT_W'($urandom_range(2, 63));
            endcase
            program_settings(kind, freq, gain, parts);

            // Every fifth phase runs back to back; the third one stalls the sink
            steady_flow = (phase_idx % 5 == 3);
            if (phase_idx == 2) begin
                hold_results = 1'b1;
            end

            phase_len = $urandom_range(40, 120);
            ramp      = ($urandom_range(0, 9) < 7);
            stamp     = $urandom;
            step      = $urandom_range(100, 4000);
            for (int k = 0; k < phase_len; k++) begin
                if ($urandom_range(0, 39) == 0) begin
                    stamp = $urandom_range(0, 1) ? '1 : '0;
                end else if (ramp) begin
                    stamp = stamp + step;
                end else begin
                    stamp = $urandom;
                end
                offer_time(stamp);
                sent++;
            end
            phase_idx++;
        end

        steady_flow = 1'b0;
        stop_offering();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (mismatch_count == 0 && pending_samples == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
